FILE: hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

    // coefficient and root widths (signed Q16.16)
    localparam int unsigned MAG_W  = 32;
    // discriminant magnitude, Q32.32 with headroom
    localparam int unsigned D_W    = 66;
    // floor square root of the discriminant
    localparam int unsigned ROOT_W = 33;
    // divider numerator: |-b +/- sqrt(D)| scaled by 2^15, or |c| scaled by 2^16
    localparam int unsigned NUM_W  = 49;

    // root count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_ANY  = 2'd3;

    // how the result of an item is formed
    typedef enum logic [1:0] {
        KIND_FIXED,  // count only, roots zero
        KIND_LIN,    // -c / b
        KIND_ONE,    // -b / (2a)
        KIND_TWO     // (-b -/+ sqrt(D)) / (2a)
    } kind_t;

    // per-item context carried alongside the square root
    typedef struct packed {
        kind_t             kind;
        logic [1:0]        fixed_count;
        logic              a_neg;
        logic [MAG_W-1:0]  a_mag;
        logic              b_neg;
        logic [MAG_W-1:0]  b_mag;
        logic              c_neg;
        logic [MAG_W-1:0]  c_mag;
    } ctx_t;

    // per-item context carried alongside the low divider
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  fixed_count;
        logic        neg;
    } fin_t;

endpackage

FILE: hw/rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one coefficient set per item (a, b, c, Q16.16 each).
//   m_axis returns one result per item: root count, two roots, clamp flag.
//   cfg_wr_en / cfg_wr_data write the zero tolerance; write it only while
//   no item is in flight.
// Timing:
//   items pass from acceptance to m_axis_tvalid through three front
//   stages (zero tests, products, discriminant), 33 square-root stages,
//   one operand stage, 32 divider stages and the output register.
//   One item per cycle is accepted while the output is free or being taken.
// Reset:
//   all valid bits clear and the tolerance returns to zero (exact zeros only).
// Stall:
//   while m_axis_tvalid is high and m_axis_tready low, the whole pipeline
//   holds and s_axis_tready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // coef_a [31:0], coef_b [63:32], coef_c [95:64]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    // root_count [1:0], root_low [33:2], root_high [65:34], saturated [66]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam logic [MAG_W-1:0] MAX_POS = {1'b0, {(MAG_W-1){1'b1}}};
    localparam logic [MAG_W-1:0] MIN_NEG = {1'b1, {(MAG_W-1){1'b0}}};

    logic              adv;
    logic [15:0]       tol_reg;

    logic              fr_valid;
    logic [D_W-1:0]    fr_rad;
    ctx_t              fr_ctx;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    ctx_t              sq_ctx;

    logic              op_valid_reg;
    logic [NUM_W-1:0]  num_lo_reg, num_hi_reg;
    logic [MAG_W-1:0]  den_reg;
    fin_t              fin_reg;
    logic              neg_hi_reg;

    logic              dl_valid, dh_valid;
    logic [MAG_W-1:0]  ql, qh;
    logic              ovl, ovh;
    fin_t              dl_fin;
    logic              dh_neg;

    logic              out_valid_reg;
    logic [1:0]        count_reg;
    logic [MAG_W-1:0]  low_reg, high_reg;
    logic              sat_reg;

    // global advance: everything moves unless a result waits unclaimed
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .coef_a    (s_axis_tdata[31:0]),
        .coef_b    (s_axis_tdata[63:32]),
        .coef_c    (s_axis_tdata[95:64]),
        .tol       (tol_reg),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_ctx   (fr_ctx)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_rad    (fr_rad),
        .in_ctx    (fr_ctx),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_ctx   (sq_ctx)
    );

    // divider operands for each case
    logic signed [34:0] nb, sv, n1, n2;
    logic [33:0]        m1, m2;
    logic [NUM_W-1:0]   num_lo_next, num_hi_next;
    logic [MAG_W-1:0]   den_next;
    fin_t               fin_next;
    logic               neg_hi_next;

    always_comb
    begin
        nb = sq_ctx.b_neg ? $signed({3'b000, sq_ctx.b_mag})
                          : -$signed({3'b000, sq_ctx.b_mag});
        sv = $signed({2'b00, sq_root});
        n1 = nb - sv;
        n2 = nb + sv;
        m1 = n1[34] ? 34'(-n1) : n1[33:0];
        m2 = n2[34] ? 34'(-n2) : n2[33:0];

        fin_next.kind        = sq_ctx.kind;
        fin_next.fixed_count = sq_ctx.fixed_count;
        den_next             = sq_ctx.a_mag;
        case (sq_ctx.kind)
            KIND_LIN:
            begin
                num_lo_next  = {1'b0, sq_ctx.c_mag, 16'd0};
                den_next     = sq_ctx.b_mag;
                fin_next.neg = (sq_ctx.c_neg == sq_ctx.b_neg);
            end
            KIND_TWO:
            begin
                num_lo_next  = {m1, 15'd0};
                fin_next.neg = n1[34] ^ sq_ctx.a_neg;
            end
            default:
            begin
                num_lo_next  = {2'b00, sq_ctx.b_mag, 15'd0};
                fin_next.neg = (sq_ctx.b_neg == sq_ctx.a_neg);
            end
        endcase
        num_hi_next = {m2, 15'd0};
        neg_hi_next = n2[34] ^ sq_ctx.a_neg;
    end

    // operand stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            op_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_lo_reg <= num_lo_next;
            num_hi_reg <= num_hi_next;
            den_reg    <= den_next;
            fin_reg    <= fin_next;
            neg_hi_reg <= neg_hi_next;
        end
    end

    qrs_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (MAG_W),
        .Q_W    (MAG_W),
        .SIDE_W ($bits(fin_t))
    ) u_div_low (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (op_valid_reg),
        .in_num    (num_lo_reg),
        .in_den    (den_reg),
        .in_side   (fin_reg),
        .out_valid (dl_valid),
        .out_quo   (ql),
        .out_ovf   (ovl),
        .out_side  (dl_fin)
    );

    qrs_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (MAG_W),
        .Q_W    (MAG_W),
        .SIDE_W (1)
    ) u_div_high (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (op_valid_reg),
        .in_num    (num_hi_reg),
        .in_den    (den_reg),
        .in_side   (neg_hi_reg),
        .out_valid (dh_valid),
        .out_quo   (qh),
        .out_ovf   (ovh),
        .out_side  (dh_neg)
    );

    // apply sign and clamp to the Q16.16 range; returns {clamped, value}
    function automatic logic [MAG_W:0] clamp(
        input logic [MAG_W-1:0] q,
        input logic             ovf,
        input logic             neg
    );
        logic [MAG_W:0] res;
        if (ovf)
        begin
            res = {1'b1, (neg ? MIN_NEG : MAX_POS)};
        end
        else if (neg)
        begin
            res = (q > MIN_NEG) ? {1'b1, MIN_NEG} : {1'b0, MAG_W'(0) - q};
        end
        else
        begin
            res = q[MAG_W-1] ? {1'b1, MAX_POS} : {1'b0, q};
        end
        return res;
    endfunction

    logic [MAG_W:0] cl_lo, cl_hi;
    logic [1:0]     count_next;
    logic [MAG_W-1:0] low_next, high_next;
    logic           sat_next;

    // result assembly
    always_comb
    begin
        cl_lo = clamp(ql, ovl, dl_fin.neg);
        cl_hi = clamp(qh, ovh, dh_neg);
        case (dl_fin.kind)
            KIND_FIXED:
            begin
                count_next = dl_fin.fixed_count;
                low_next   = '0;
                high_next  = '0;
                sat_next   = 1'b0;
            end
            KIND_TWO:
            begin
                count_next = CNT_TWO;
                low_next   = cl_lo[MAG_W-1:0];
                high_next  = cl_hi[MAG_W-1:0];
                sat_next   = cl_lo[MAG_W] | cl_hi[MAG_W];
            end
            default:
            begin
                count_next = CNT_ONE;
                low_next   = cl_lo[MAG_W-1:0];
                high_next  = cl_lo[MAG_W-1:0];
                sat_next   = cl_lo[MAG_W];
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dl_valid & dh_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, sat_reg, high_reg, low_reg, count_reg};

`ifndef ASSERT_OFF
    // no roots and no clamp unless a root count is reported
    a_empty_roots: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (count_reg == CNT_NONE || count_reg == CNT_ANY)
        |-> low_reg == '0 && high_reg == '0 && !sat_reg)
        else $error("roots or clamp reported with no root count");

    // a single root appears in both fields
    a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && count_reg == CNT_ONE |-> low_reg == high_reg)
        else $error("single root differs between fields");

    // input side only stalls behind an unclaimed result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without an output stall");

    // both divider lanes carry the same items
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dl_valid == dh_valid)
        else $error("divider lanes out of step");
`endif

endmodule

FILE: hw/rtl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Front end: magnitudes and zero tests, the two products, then the
// discriminant in sign-magnitude form and the case decode.
// ----------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic signed [MAG_W-1:0] coef_a,
    input  logic signed [MAG_W-1:0] coef_b,
    input  logic signed [MAG_W-1:0] coef_c,
    input  logic [15:0]             tol,
    output logic                    out_valid,
    output logic [D_W-1:0]          out_rad,
    output ctx_t                    out_ctx
);

    // stage 1 registers
    logic             v1_reg;
    logic             a_neg1_reg, b_neg1_reg, c_neg1_reg;
    logic [MAG_W-1:0] a_mag1_reg, b_mag1_reg, c_mag1_reg;
    logic             nz_a1_reg, nz_b1_reg, nz_c1_reg;

    // stage 2 registers
    logic             v2_reg;
    logic             a_neg2_reg, b_neg2_reg, c_neg2_reg;
    logic [MAG_W-1:0] a_mag2_reg, b_mag2_reg, c_mag2_reg;
    logic             nz_a2_reg, nz_b2_reg, nz_c2_reg;
    logic [63:0]      b2_reg, p_reg;

    // stage 3 registers
    logic             v3_reg;
    logic [D_W-1:0]   rad_reg;
    ctx_t             ctx_reg;

    logic [MAG_W-1:0] a_mag_next, b_mag_next, c_mag_next;
    logic [D_W-1:0]   pl, b2e, dmag;
    logic             dneg, dzero;
    ctx_t             ctx_next;

    // magnitudes of the incoming coefficients
    assign a_mag_next = coef_a[MAG_W-1] ? (MAG_W'(0) - coef_a) : coef_a;
    assign b_mag_next = coef_b[MAG_W-1] ? (MAG_W'(0) - coef_b) : coef_b;
    assign c_mag_next = coef_c[MAG_W-1] ? (MAG_W'(0) - coef_c) : coef_c;

    // discriminant b*b - 4*a*c as sign and magnitude
    always_comb
    begin
        pl   = {p_reg, 2'b00};
        b2e  = {2'b00, b2_reg};
        dneg = 1'b0;
        if (a_neg2_reg != c_neg2_reg)
        begin
            dmag = b2e + pl;
        end
        else if (pl <= b2e)
        begin
            dmag = b2e - pl;
        end
        else
        begin
            dmag = pl - b2e;
            dneg = 1'b1;
        end
        dzero = (dmag[D_W-1:64] == '0)
              && ((dmag[63:0] == '0) || (dmag[63:0] < {32'd0, tol, 16'd0}));
    end

    // case decode
    always_comb
    begin
        ctx_next.a_neg       = a_neg2_reg;
        ctx_next.a_mag       = a_mag2_reg;
        ctx_next.b_neg       = b_neg2_reg;
        ctx_next.b_mag       = b_mag2_reg;
        ctx_next.c_neg       = c_neg2_reg;
        ctx_next.c_mag       = c_mag2_reg;
        ctx_next.fixed_count = CNT_NONE;
        if (nz_a2_reg)
        begin
            if (nz_b2_reg)
            begin
                ctx_next.kind        = KIND_FIXED;
                ctx_next.fixed_count = nz_c2_reg ? CNT_ANY : CNT_NONE;
            end
            else
            begin
                ctx_next.kind = KIND_LIN;
            end
        end
        else if (dzero)
        begin
            ctx_next.kind = KIND_ONE;
        end
        else if (!dneg)
        begin
            ctx_next.kind = KIND_TWO;
        end
        else
        begin
            ctx_next.kind = KIND_FIXED;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_neg1_reg <= coef_a[MAG_W-1];
            b_neg1_reg <= coef_b[MAG_W-1];
            c_neg1_reg <= coef_c[MAG_W-1];
            a_mag1_reg <= a_mag_next;
            b_mag1_reg <= b_mag_next;
            c_mag1_reg <= c_mag_next;
            nz_a1_reg  <= (a_mag_next == '0) || (a_mag_next < {16'd0, tol});
            nz_b1_reg  <= (b_mag_next == '0) || (b_mag_next < {16'd0, tol});
            nz_c1_reg  <= (c_mag_next == '0) || (c_mag_next < {16'd0, tol});

            a_neg2_reg <= a_neg1_reg;
            b_neg2_reg <= b_neg1_reg;
            c_neg2_reg <= c_neg1_reg;
            a_mag2_reg <= a_mag1_reg;
            b_mag2_reg <= b_mag1_reg;
            c_mag2_reg <= c_mag1_reg;
            nz_a2_reg  <= nz_a1_reg;
            nz_b2_reg  <= nz_b1_reg;
            nz_c2_reg  <= nz_c1_reg;
            b2_reg     <= b_mag1_reg * b_mag1_reg;
            p_reg      <= a_mag1_reg * c_mag1_reg;

            rad_reg    <= dmag;
            ctx_reg    <= ctx_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_rad   = rad_reg;
    assign out_ctx   = ctx_reg;

endmodule

FILE: hw/rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [D_W-1:0]    in_rad,
    input  ctx_t              in_ctx,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output ctx_t              out_ctx
);

    localparam int unsigned STEPS = ROOT_W;
    localparam int unsigned REM_W = ROOT_W + 3;

    logic              vld_reg  [1:STEPS];
    logic [D_W-1:0]    rad_reg  [1:STEPS];
    logic [REM_W-1:0]  rem_reg  [1:STEPS];
    logic [ROOT_W-1:0] root_reg [1:STEPS];
    ctx_t              ctx_reg  [1:STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic              vld_in;
        logic [D_W-1:0]    rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        ctx_t              ctx_in;
        logic [REM_W-1:0]  rem_s, trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign ctx_in  = in_ctx;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k];
            assign rad_in  = rad_reg[k];
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign ctx_in  = ctx_reg[k];
        end

        // bring down two radicand bits and try the next root bit
        assign rem_s = {rem_in[REM_W-3:0], rad_in[D_W-1:D_W-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (rem_s >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[k+1]  <= {rad_in[D_W-3:0], 2'b00};
                rem_reg[k+1]  <= ge ? (rem_s - trial) : rem_s;
                root_reg[k+1] <= {root_in[ROOT_W-2:0], ge};
                ctx_reg[k+1]  <= ctx_in;
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign out_root  = root_reg[STEPS];
    assign out_ctx   = ctx_reg[STEPS];

endmodule

FILE: hw/rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit the quotient width.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int unsigned NUM_W  = 49,
    parameter int unsigned DEN_W  = 32,
    parameter int unsigned Q_W    = 32,
    parameter int unsigned SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quo,
    output logic              out_ovf,
    output logic [SIDE_W-1:0] out_side
);

    localparam int unsigned HI_W  = NUM_W - Q_W;
    localparam int unsigned CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic              vld_reg  [1:Q_W];
    logic [Q_W-1:0]    low_reg  [1:Q_W];
    logic [DEN_W-1:0]  den_reg  [1:Q_W];
    logic [DEN_W-1:0]  rem_reg  [1:Q_W];
    logic [Q_W-1:0]    quo_reg  [1:Q_W];
    logic              ovf_reg  [1:Q_W];
    logic [SIDE_W-1:0] side_reg [1:Q_W];

    // quotient too wide when the upper numerator part reaches the divisor
    logic ovf_first;
    assign ovf_first = (CMP_W'(in_num[NUM_W-1:Q_W]) >= CMP_W'(in_den));

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic              vld_in, ovf_in;
        logic [Q_W-1:0]    low_in, quo_in;
        logic [DEN_W-1:0]  den_in, rem_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    rem_s;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign low_in  = in_num[Q_W-1:0];
            assign den_in  = in_den;
            // upper numerator part is the starting remainder
            assign rem_in  = DEN_W'(in_num[NUM_W-1:Q_W]);
            assign quo_in  = '0;
            assign ovf_in  = ovf_first;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k];
            assign low_in  = low_reg[k];
            assign den_in  = den_reg[k];
            assign rem_in  = rem_reg[k];
            assign quo_in  = quo_reg[k];
            assign ovf_in  = ovf_reg[k];
            assign side_in = side_reg[k];
        end

        // bring down one numerator bit and try a subtract
        assign rem_s = {rem_in, low_in[Q_W-1-k]};
        assign ge    = (rem_s >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                low_reg[k+1]  <= low_in;
                den_reg[k+1]  <= den_in;
                rem_reg[k+1]  <= ge ? DEN_W'(rem_s - {1'b0, den_in}) : rem_s[DEN_W-1:0];
                quo_reg[k+1]  <= {quo_in[Q_W-2:0], ge};
                ovf_reg[k+1]  <= ovf_in;
                side_reg[k+1] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign out_quo   = quo_reg[Q_W];
    assign out_ovf   = ovf_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule
